// ===== rtl/core/soa_pkg.sv =====
// Shared types and constants for the slab object allocator.
package soa_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_INVALID   = 3'd4,
    ST_DOUBLE    = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FIND_PAGE,
    S_INIT_PAGE,
    S_POP_RD,
    S_POP_WR,
    S_FREE_RD,
    S_FREE_CHK,
    S_UNLINK_RD,
    S_UNLINK_CHK,
    S_CLEAR,
    S_DONE
  } state_t;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;
  localparam logic [3:0] NOT_SLAB = 4'd15;

endpackage

// ===== rtl/core/soa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module soa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/slab_object_allocator.sv =====
// Slab object allocator top level: page table, free stacks and control sequencer.
//
//   channel | dir | tdata fields (low bit up)                      | tuser
//   in_     | in  | request_bytes[11:0], object_address[29:12]     | func
//   out_    | out | status[2:0], result_address[20:3]              | page_released
//
// After reset a clearing pass walks every page table entry with in_tready low. An
// allocate takes a free object from its bucket's pages or else from an unused pool page,
// whose objects it first pushes; a free checks the page and the object's mark, pushes it
// and, on a release, reads the page's link and walks the bucket list to unlink it.
// in_tready rises once the result is taken and S_IDLE is reached. Tables sit in
// registered-read RAMs, bucket heads in flops; one request is worked at a time. The result
// is in an output register; a stalled out_tready holds the sequencer in its final state.
module slab_object_allocator
  import soa_pkg::*;
#(
  parameter int POOL_PAGES           = 64,
  parameter int PAGE_BYTES           = 4096,
  parameter int HEADER_BYTES         = 48,
  parameter int BUCKET_COUNT         = 9,
  parameter int MAX_OBJECTS_PER_PAGE = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // request_bytes[11:0], object_address[29:12]
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status[2:0], result_address[20:3]
  output logic        out_tuser   // page_released
);
  localparam int PW  = $clog2(POOL_PAGES);
  localparam int PLW = PW + 1;                       // page id with null marker
  localparam int OW  = $clog2(MAX_OBJECTS_PER_PAGE);
  localparam int CW  = OW + 1;
  localparam int SW  = PW + OW;
  localparam int OFW = $clog2(PAGE_BYTES);
  localparam int BW  = 4;
  // log2 of the largest bucket a 12-bit size can reach
  localparam int MAX_LOG = (BUCKET_COUNT + 2 < 12) ? BUCKET_COUNT + 2 : 12;
  localparam logic [PLW-1:0] NULL_PG = PLW'(POOL_PAGES);
  localparam int PT_W = 1 + BW + CW;                 // in_use, bucket, free_count

  // ------------------------------------------------------------------ memories
  logic           pt_we;  logic [PW-1:0] pt_wa, pt_ra;
  logic [PT_W-1:0] pt_wd, pt_rd;
  logic           ln_we;  logic [PW-1:0] ln_wa, ln_ra;
  logic [PLW-1:0] ln_wd, ln_rd;
  logic           sk_we;  logic [SW-1:0] sk_wa, sk_ra;
  logic [OW-1:0]  sk_wd, sk_rd;
  logic           mk_we;  logic [SW-1:0] mk_wa, mk_ra;
  logic [0:0]     mk_wd, mk_rd;

  soa_ram #(.WIDTH(PT_W), .DEPTH(POOL_PAGES)) u_page_tab (
    .clk, .we(pt_we), .waddr(pt_wa), .wdata(pt_wd), .raddr(pt_ra), .rdata(pt_rd));
  soa_ram #(.WIDTH(PLW), .DEPTH(POOL_PAGES)) u_link (
    .clk, .we(ln_we), .waddr(ln_wa), .wdata(ln_wd), .raddr(ln_ra), .rdata(ln_rd));
  soa_ram #(.WIDTH(OW), .DEPTH(POOL_PAGES*MAX_OBJECTS_PER_PAGE)) u_stack (
    .clk, .we(sk_we), .waddr(sk_wa), .wdata(sk_wd), .raddr(sk_ra), .rdata(sk_rd));
  soa_ram #(.WIDTH(1), .DEPTH(POOL_PAGES*MAX_OBJECTS_PER_PAGE)) u_mark (
    .clk, .we(mk_we), .waddr(mk_wa), .wdata(mk_wd), .raddr(mk_ra), .rdata(mk_rd));

  logic           rd_use;
  logic [BW-1:0]  rd_bkt;
  logic [CW-1:0]  rd_cnt;
  assign {rd_use, rd_bkt, rd_cnt} = pt_rd;

  // bucket heads live in flops (few entries)
  logic [PLW-1:0] head_r [BUCKET_COUNT];

  // ------------------------------------------------------------------ registers
  state_t         state_r, state_nxt;
  logic           func_r;
  logic [11:0]    size_r;
  logic [17:0]    addr_r;
  logic [BW-1:0]  bkt_r,  bkt_nxt;
  logic [3:0]     lg_r,   lg_nxt;     // log2 of bucket size
  logic [CW-1:0]  cap_r,  cap_nxt;
  logic [PLW-1:0] pg_r,   pg_nxt;     // current page or list cursor
  logic [PLW-1:0] prev_r, prev_nxt;   // unlink predecessor
  logic [PLW-1:0] succ_r, succ_nxt;   // link of page being unlinked
  logic [PW:0]    cnt_r,  cnt_nxt;    // scan guard / search index
  logic [CW-1:0]  fc_r,   fc_nxt;
  logic [OW-1:0]  idx_r,  idx_nxt;
  logic [CW-1:0]  ini_r,  ini_nxt;
  logic [2:0]     st_r,   st_nxt;
  logic [17:0]    ra_r,   ra_nxt;
  logic           rel_r,  rel_nxt;
  logic           ov_r;

  // capacity of a bucket by its log2 size
  function automatic logic [CW-1:0] cap_of(input logic [3:0] lg);
    int n;
    n = (PAGE_BYTES - HEADER_BYTES) >> lg;
    if (n > MAX_OBJECTS_PER_PAGE) n = MAX_OBJECTS_PER_PAGE;
    return CW'(n);
  endfunction

  // free-path address decode
  logic [PW-1:0]  f_pg;
  logic [OFW-1:0] f_off;
  logic           f_in_pool;
  logic [OFW-1:0] f_rel;
  logic [OFW-1:0] f_mask;
  logic [OFW-1:0] f_idx_w;
  assign f_in_pool = (32'(addr_r) >> OFW) < 32'(POOL_PAGES);
  assign f_pg  = PW'(32'(addr_r) >> OFW);
  assign f_off = OFW'(addr_r);
  assign f_rel = f_off - OFW'(HEADER_BYTES);
  assign f_mask = (OFW'(1) << lg_r) - OFW'(1);
  assign f_idx_w = f_rel >> lg_r;

  logic [17:0] obj_addr;
  assign obj_addr = 18'((32'(pg_r[PW-1:0]) * PAGE_BYTES) + HEADER_BYTES
                        + (32'(sk_rd) << lg_r));

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = {3'b0, ra_r, st_r};
  assign out_tuser  = rel_r;

  // ------------------------------------------------------------------ next state / datapath
  always_comb begin
    state_nxt = state_r;
    bkt_nxt = bkt_r;  lg_nxt = lg_r;  cap_nxt = cap_r;  pg_nxt = pg_r;
    prev_nxt = prev_r; succ_nxt = succ_r; cnt_nxt = cnt_r; fc_nxt = fc_r;
    idx_nxt = idx_r;  ini_nxt = ini_r;  st_nxt = st_r;  ra_nxt = ra_r;  rel_nxt = rel_r;
    pt_we = 1'b0; pt_wa = pg_r[PW-1:0]; pt_wd = '0; pt_ra = pg_r[PW-1:0];
    ln_we = 1'b0; ln_wa = pg_r[PW-1:0]; ln_wd = '0; ln_ra = pg_r[PW-1:0];
    sk_we = 1'b0; sk_wa = '0; sk_wd = '0; sk_ra = '0;
    mk_we = 1'b0; mk_wa = '0; mk_wd = '0; mk_ra = '0;
    unique case (state_r)
      S_CLEAR: begin
        pt_we = 1'b1; pt_wa = cnt_r[PW-1:0]; pt_wd = {1'b0, NOT_SLAB, CW'(0)};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (PW+1)'(POOL_PAGES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        st_nxt = ST_OK; ra_nxt = '0; rel_nxt = 1'b0; cnt_nxt = '0;
        if (func_r == FUNC_ALLOC) begin
          lg_nxt = 4'd3; bkt_nxt = '0;
          for (int b = MAX_LOG; b >= 3; b--)
            if ({1'b0, size_r} <= 13'(1 << b)) begin
              lg_nxt = 4'(b); bkt_nxt = BW'(b - 3);
            end
          if (size_r == '0) begin
            st_nxt = ST_ZERO; state_nxt = S_DONE;
          end else if ({1'b0, size_r} > 13'(1 << MAX_LOG) ||
                       32'(bkt_nxt) >= BUCKET_COUNT || cap_of(lg_nxt) == '0) begin
            st_nxt = ST_TOO_LARGE; state_nxt = S_DONE;
          end else begin
            cap_nxt = cap_of(lg_nxt);
            pg_nxt = head_r[bkt_nxt];
            state_nxt = S_SCAN_RD;
          end
        end else begin
          if (!f_in_pool) begin
            st_nxt = ST_INVALID; state_nxt = S_DONE;
          end else begin
            pg_nxt = {1'b0, f_pg};
            state_nxt = S_FREE_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (pg_r == NULL_PG || 32'(cnt_r) >= POOL_PAGES) begin
          cnt_nxt = '0; state_nxt = S_FIND_PAGE;
          pt_ra = '0;
        end else begin
          pt_ra = pg_r[PW-1:0]; ln_ra = pg_r[PW-1:0];
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (rd_cnt != '0) begin
          fc_nxt = rd_cnt - 1'b1;
          state_nxt = S_POP_RD;
        end else begin
          pg_nxt = ln_rd; cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_FIND_PAGE: begin
        // page table read issued last cycle for cnt_r
        pt_ra = PW'(cnt_r + 1'b1);
        if (!rd_use) begin
          pg_nxt = {1'b0, cnt_r[PW-1:0]};
          ini_nxt = '0;
          ln_we = 1'b1; ln_wa = cnt_r[PW-1:0]; ln_wd = head_r[bkt_r];
          state_nxt = S_INIT_PAGE;
        end else if (32'(cnt_r) == POOL_PAGES - 1) begin
          st_nxt = ST_EXHAUSTED; state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_INIT_PAGE: begin
        sk_we = 1'b1; sk_wa = {pg_r[PW-1:0], ini_r[OW-1:0]}; sk_wd = ini_r[OW-1:0];
        mk_we = 1'b1; mk_wa = {pg_r[PW-1:0], ini_r[OW-1:0]}; mk_wd = 1'b1;
        ini_nxt = ini_r + 1'b1;
        if (ini_r == cap_r - 1'b1) begin
          fc_nxt = cap_r - 1'b1;
          state_nxt = S_POP_RD;
        end
      end
      S_POP_RD: begin
        sk_ra = {pg_r[PW-1:0], fc_r[OW-1:0]};
        state_nxt = S_POP_WR;
      end
      S_POP_WR: begin
        mk_we = 1'b1; mk_wa = {pg_r[PW-1:0], sk_rd}; mk_wd = 1'b0;
        pt_we = 1'b1; pt_wa = pg_r[PW-1:0]; pt_wd = {1'b1, bkt_r, fc_r};
        ra_nxt = obj_addr;
        state_nxt = S_DONE;
      end
      S_FREE_RD: begin
        pt_ra = f_pg;
        state_nxt = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        // decode page here (lg_r loaded); S_UNLINK_RD then validates the address, S_UNLINK_CHK checks the mark
        if (!rd_use || 32'(rd_bkt) >= BUCKET_COUNT) begin
          st_nxt = ST_INVALID; state_nxt = S_DONE;
        end else begin
          lg_nxt = 4'(rd_bkt) + 4'd3;
          bkt_nxt = rd_bkt;
          cap_nxt = cap_of(4'(rd_bkt) + 4'd3);
          fc_nxt = rd_cnt;
          state_nxt = S_UNLINK_RD; cnt_nxt = '1;  // marks "validate" phase
        end
      end
      S_UNLINK_RD: begin
        if (cnt_r == '1) begin
          // validate object address with lg_r now known
          idx_nxt = OW'(f_idx_w);
          if (f_off < OFW'(HEADER_BYTES) || (f_rel & f_mask) != '0 ||
              (32'(f_idx_w) >= 32'(cap_r))) begin
            st_nxt = ST_INVALID; state_nxt = S_DONE;
          end else begin
            mk_ra = {pg_r[PW-1:0], OW'(f_idx_w)};
            cnt_nxt = '0;
            state_nxt = S_UNLINK_CHK;
            prev_nxt = NULL_PG;
            succ_nxt = '1;
          end
        end else begin
          ln_ra = (prev_r == NULL_PG) ? pg_r[PW-1:0] : prev_r[PW-1:0];
          state_nxt = S_UNLINK_CHK;
        end
      end
      S_UNLINK_CHK: begin
        if (succ_r == '1) begin
          // mark result available
          if (mk_rd[0] || fc_r >= cap_r) begin
            st_nxt = ST_DOUBLE; state_nxt = S_DONE;
          end else begin
            sk_we = 1'b1; sk_wa = {pg_r[PW-1:0], fc_r[OW-1:0]}; sk_wd = idx_r;
            mk_we = 1'b1; mk_wa = {pg_r[PW-1:0], idx_r}; mk_wd = 1'b1;
            if (fc_r + 1'b1 >= cap_r) begin
              rel_nxt = 1'b1;
              pt_we = 1'b1; pt_wd = {1'b0, NOT_SLAB, CW'(0)};
              succ_nxt = NULL_PG;
              // read link of freed page first
              state_nxt = S_UNLINK_RD;
            end else begin
              pt_we = 1'b1; pt_wd = {1'b1, bkt_r, fc_r + 1'b1};
              state_nxt = S_DONE;
            end
          end
        end else if (prev_r == NULL_PG && succ_r == NULL_PG) begin
          // got the freed page's own link
          succ_nxt = ln_rd;
          if (head_r[bkt_r] == pg_r) begin
            state_nxt = S_DONE;   // head updated in register block
          end else begin
            prev_nxt = head_r[bkt_r];
            state_nxt = S_UNLINK_RD;
          end
        end else begin
          if (ln_rd == pg_r) begin
            ln_we = 1'b1; ln_wa = prev_r[PW-1:0]; ln_wd = succ_r;
            state_nxt = S_DONE;
          end else if (ln_rd == NULL_PG || 32'(cnt_r) >= POOL_PAGES) begin
            state_nxt = S_DONE;
          end else begin
            prev_nxt = ln_rd; cnt_nxt = cnt_r + 1'b1;
            state_nxt = S_UNLINK_RD;
          end
        end
      end
      S_DONE: begin
        if (!ov_r) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------ registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < BUCKET_COUNT; i++) head_r[i] <= NULL_PG;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_IDLE && in_tvalid) begin
        func_r <= in_tuser;
        size_r <= in_tdata[11:0];
        addr_r <= in_tdata[29:12];
      end
      if (state_r == S_FIND_PAGE && !rd_use)
        head_r[bkt_r] <= {1'b0, cnt_r[PW-1:0]};
      if (state_r == S_UNLINK_CHK && succ_r != '1 && prev_r == NULL_PG &&
          succ_r == NULL_PG && head_r[bkt_r] == pg_r)
        head_r[bkt_r] <= ln_rd;
      if (state_r != S_DONE && state_nxt == S_DONE)
        ov_r <= 1'b1;
      else if (ov_r && out_tready)
        ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    bkt_r <= bkt_nxt; lg_r <= lg_nxt; cap_r <= cap_nxt; pg_r <= pg_nxt;
    prev_r <= prev_nxt; succ_r <= succ_nxt; fc_r <= fc_nxt; idx_r <= idx_nxt;
    ini_r <= ini_nxt; st_r <= st_nxt; ra_r <= ra_nxt; rel_r <= rel_nxt;
  end

endmodule

// ===== rtl/core/soa_checker.sv =====
// Port-level checker for the slab object allocator, bound to the top level.
module soa_checker
  import soa_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);
  // one request at a time: no input taken while a result waits
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input accepted while result pending");

  // a nonzero address only with ok status
  a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20:3] != 18'd0 |-> out_tdata[2:0] == ST_OK)
    else $error("address with failing status");

  // page release only on a successful free
  a_rel_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[2:0] == ST_OK && out_tdata[20:3] == 18'd0)
    else $error("release with bad status");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
endmodule

bind slab_object_allocator soa_checker u_soa_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tuser);
